// ===== hdl/brld_pkg.sv =====
// ----------------------------------------------------------------------------
// brld_pkg
// Shared types and constants for the byte run-length decoder: register
// indexes, error codes and the command and status groups between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package brld_pkg;

    localparam int LENGTH_BITS_DEFAULT = 24;
    localparam int BYTE_BITS           = 8;
    localparam int COUNT_BITS          = 2;
    localparam int CFG_INDEX_BITS      = 1;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_OUTPUT_LENGTH = 1'b0,
        CFG_SOURCE_LENGTH = 1'b1
    } t_cfg_reg;

    typedef enum logic [1:0] {
        ERR_NONE   = 2'd0,
        ERR_SOURCE = 2'd1,
        ERR_DEST   = 2'd2
    } t_err;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic start;
        logic m_ctrl;
        logic m_lit;
        logic m_rep;
        logic emit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_free;
        logic skip;
        logic fail;
        logic lit_ctrl;
        logic lit_last;
        logic done;
        logic rep_more;
        logic left_last;
        logic done_reg;
    } t_status;

endpackage

// ===== hdl/brld_ctrl.sv =====
// ----------------------------------------------------------------------------
// brld_ctrl
// Decode-mode state machine: tracks control, literal, repeat and halted
// modes, drives the input stall and steps the repeat emission.
// ----------------------------------------------------------------------------
module brld_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_stream_start,
    input  brld_pkg::t_status i_status,
    output logic              o_in_stall,
    output brld_pkg::t_cmd    o_cmd
);
    import brld_pkg::*;

    typedef enum logic [4:0] {
        S_CTRL = 5'b00001,
        S_LIT  = 5'b00010,
        S_REP  = 5'b00100,
        S_HALT = 5'b01000,
        S_EMIT = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;
    t_state eff_state;
    logic   accept_ok;
    logic   accept;

    assign eff_state  = i_stream_start ? S_CTRL : r_state;
    assign accept_ok  = (r_state != S_EMIT) && i_status.out_free;
    assign accept     = i_in_valid && accept_ok;
    assign o_in_stall = !accept_ok;

    always_comb begin
        o_cmd        = '0;
        o_cmd.load   = accept;
        o_cmd.start  = i_stream_start;
        o_cmd.m_ctrl = accept && (eff_state == S_CTRL);
        o_cmd.m_lit  = accept && (eff_state == S_LIT);
        o_cmd.m_rep  = accept && (eff_state == S_REP);
        o_cmd.emit   = (r_state == S_EMIT) && i_status.out_free;
    end

    always_comb begin
        n_state = r_state;
        if (accept) begin
            n_state = eff_state;
            if (!i_status.skip) begin
                unique case (eff_state)
                    S_CTRL: begin
                        if (i_status.fail) n_state = S_HALT;
                        else if (i_status.lit_ctrl) n_state = S_LIT;
                        else n_state = S_REP;
                    end
                    S_LIT: begin
                        if (i_status.done) n_state = S_HALT;
                        else if (i_status.lit_last) n_state = S_CTRL;
                        else n_state = S_LIT;
                    end
                    S_REP: begin
                        if (i_status.fail) n_state = S_HALT;
                        else if (i_status.rep_more) n_state = S_EMIT;
                        else if (i_status.done) n_state = S_HALT;
                        else n_state = S_CTRL;
                    end
                    default: begin
                        n_state = eff_state;
                    end
                endcase
            end
        end else if ((r_state == S_EMIT) && i_status.out_free && i_status.left_last) begin
            n_state = i_status.done_reg ? S_HALT : S_CTRL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CTRL;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== hdl/brld_dp.sv =====
// ----------------------------------------------------------------------------
// brld_dp
// Datapath: length registers, source and destination counters, bound
// checks, run counters and the registered two-byte result stage.
// ----------------------------------------------------------------------------
module brld_dp #(
    parameter int LENGTH_BITS = brld_pkg::LENGTH_BITS_DEFAULT
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [brld_pkg::CFG_INDEX_BITS-1:0]  i_cfg_index,
    input  logic [LENGTH_BITS-1:0]               i_cfg_data,
    input  logic [brld_pkg::BYTE_BITS-1:0]       i_in_byte,
    input  logic                                 i_out_stall,
    input  brld_pkg::t_cmd                       i_cmd,
    output brld_pkg::t_status                    o_status,
    output logic                                 o_out_valid,
    output logic [brld_pkg::BYTE_BITS-1:0]       o_byte_a,
    output logic [brld_pkg::BYTE_BITS-1:0]       o_byte_b,
    output logic [brld_pkg::COUNT_BITS-1:0]      o_byte_count,
    output logic [1:0]                           o_error_code,
    output logic                                 o_run_last,
    output logic                                 o_stream_done
);
    import brld_pkg::*;

    typedef logic [LENGTH_BITS-1:0] t_len;
    typedef logic [LENGTH_BITS:0]   t_ext;
    typedef logic [BYTE_BITS:0]     t_total;

    t_len                  r_output_length;
    t_len                  r_source_length;
    t_len                  r_source_count,  n_source_count;
    t_len                  r_dest_count,    n_dest_count;
    logic [BYTE_BITS-1:0]  r_run_remaining, n_run_remaining;
    logic [BYTE_BITS-1:0]  r_repeat_length, n_repeat_length;
    t_total                r_left,          n_left;
    logic [BYTE_BITS-1:0]  r_rep_byte;
    logic                  r_done;

    logic                  r_out_valid;
    logic [BYTE_BITS-1:0]  r_byte_a,  n_byte_a;
    logic [BYTE_BITS-1:0]  r_byte_b,  n_byte_b;
    logic [COUNT_BITS-1:0] r_byte_count, n_byte_count;
    t_err                  r_error_code, n_error_code;
    logic                  r_run_last, n_run_last;
    logic                  r_stream_done, n_stream_done;
    logic                  res_load;

    t_len                  sc, dc, sc1;
    logic [BYTE_BITS-1:0]  rr, rl, lit_n;
    t_total                total;
    logic                  out_free, skip, active, byte_neg;
    logic                  f1_lit, f2_lit, f1_rep_ctrl, f2_rep, done;
    logic                  err_src, err_dst, fail;
    logic [COUNT_BITS-1:0] first_cnt, emit_cnt;

    assign out_free = !r_out_valid || !i_out_stall;

    assign sc       = i_cmd.start ? '0 : r_source_count;
    assign dc       = i_cmd.start ? '0 : r_dest_count;
    assign rr       = i_cmd.start ? '0 : r_run_remaining;
    assign rl       = i_cmd.start ? '0 : r_repeat_length;
    assign sc1      = sc + t_len'(1);
    assign skip     = (sc >= r_source_length);
    assign active   = i_cmd.load && !skip;
    assign byte_neg = i_in_byte[BYTE_BITS-1];
    assign lit_n    = (~i_in_byte) + 8'd1;
    assign total    = t_total'(rl) + t_total'(1);
    assign done     = (sc1 == r_source_length);

    assign f1_lit      = (t_ext'(sc1) + t_ext'(lit_n)) > t_ext'(r_source_length);
    assign f2_lit      = (t_ext'(dc) + t_ext'(lit_n)) > t_ext'(r_output_length);
    assign f1_rep_ctrl = (sc1 >= r_source_length);
    assign f2_rep      = (t_ext'(dc) + t_ext'(total)) > t_ext'(r_output_length);

    assign err_src = active && i_cmd.m_ctrl && (byte_neg ? f1_lit : f1_rep_ctrl);
    assign err_dst = active && !err_src
                   && ((i_cmd.m_ctrl && byte_neg && f2_lit) || (i_cmd.m_rep && f2_rep));
    assign fail    = err_src || err_dst;

    assign first_cnt = (total >= t_total'(2)) ? 2'd2 : 2'd1;
    assign emit_cnt  = (r_left >= t_total'(2)) ? 2'd2 : 2'd1;

    always_comb begin
        o_status           = '0;
        o_status.out_free  = out_free;
        o_status.skip      = skip;
        o_status.fail      = fail;
        o_status.lit_ctrl  = byte_neg;
        o_status.lit_last  = (rr <= 8'd1);
        o_status.done      = done;
        o_status.rep_more  = (total > t_total'(2));
        o_status.left_last = (r_left <= t_total'(2));
        o_status.done_reg  = r_done;
    end

    always_comb begin
        n_source_count  = sc;
        n_dest_count    = dc;
        n_run_remaining = rr;
        n_repeat_length = rl;
        n_left          = r_left;
        res_load        = 1'b0;
        n_byte_a        = '0;
        n_byte_b        = '0;
        n_byte_count    = '0;
        n_error_code    = ERR_NONE;
        n_run_last      = 1'b1;
        n_stream_done   = 1'b0;
        if (!i_cmd.load) begin
            n_source_count  = r_source_count;
            n_dest_count    = r_dest_count;
            n_run_remaining = r_run_remaining;
            n_repeat_length = r_repeat_length;
        end
        if (active && (i_cmd.m_ctrl || i_cmd.m_lit || i_cmd.m_rep)) begin
            n_source_count = sc1;
        end
        if (fail) begin
            res_load     = 1'b1;
            n_error_code = err_src ? ERR_SOURCE : ERR_DEST;
        end else if (active && i_cmd.m_ctrl) begin
            if (byte_neg) n_run_remaining = lit_n;
            else n_repeat_length = i_in_byte;
        end else if (active && i_cmd.m_lit) begin
            n_dest_count    = dc + t_len'(1);
            n_run_remaining = (rr != 8'd0) ? rr - 8'd1 : 8'd0;
            res_load        = 1'b1;
            n_byte_a        = i_in_byte;
            n_byte_count    = 2'd1;
            n_stream_done   = done;
        end else if (active && i_cmd.m_rep) begin
            n_dest_count  = dc + t_len'(total);
            n_left        = total - t_total'(first_cnt);
            res_load      = 1'b1;
            n_byte_a      = i_in_byte;
            n_byte_b      = (first_cnt == 2'd2) ? i_in_byte : '0;
            n_byte_count  = first_cnt;
            n_run_last    = (total <= t_total'(2));
            n_stream_done = done;
        end else if (i_cmd.emit) begin
            n_left        = r_left - t_total'(emit_cnt);
            res_load      = 1'b1;
            n_byte_a      = r_rep_byte;
            n_byte_b      = (emit_cnt == 2'd2) ? r_rep_byte : '0;
            n_byte_count  = emit_cnt;
            n_run_last    = (r_left <= t_total'(2));
            n_stream_done = r_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_output_length <= '0;
            r_source_length <= '0;
            r_source_count  <= '0;
            r_dest_count    <= '0;
            r_run_remaining <= '0;
            r_repeat_length <= '0;
            r_left          <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            if (i_cfg_we && (i_cfg_index == CFG_OUTPUT_LENGTH)) begin
                r_output_length <= i_cfg_data;
            end
            if (i_cfg_we && (i_cfg_index == CFG_SOURCE_LENGTH)) begin
                r_source_length <= i_cfg_data;
            end
            r_source_count  <= n_source_count;
            r_dest_count    <= n_dest_count;
            r_run_remaining <= n_run_remaining;
            r_repeat_length <= n_repeat_length;
            r_left          <= n_left;
            r_out_valid     <= res_load || (r_out_valid && i_out_stall);
        end
    end

    // payload of the result stage
    always_ff @(posedge i_clk) begin
        if (active && i_cmd.m_rep) begin
            r_rep_byte <= i_in_byte;
            r_done     <= done;
        end
        if (res_load) begin
            r_byte_a      <= n_byte_a;
            r_byte_b      <= n_byte_b;
            r_byte_count  <= n_byte_count;
            r_error_code  <= n_error_code;
            r_run_last    <= n_run_last;
            r_stream_done <= n_stream_done;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_byte_a      = r_byte_a;
    assign o_byte_b      = r_byte_b;
    assign o_byte_count  = r_byte_count;
    assign o_error_code  = r_error_code;
    assign o_run_last    = r_run_last;
    assign o_stream_done = r_stream_done;

endmodule

// ===== hdl/byte_run_length_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// byte_run_length_decoder_unit
// A result is written to the output register in the cycle after its transfer.
// Throughput: control and literal bytes at one per cycle while the output is free;
// a repeat data byte with count n+1 holds off further input until its run is emitted,
// up to two bytes per result. The two-byte result register sets the repeat rate.
// Reset (synchronous, active low) clears lengths, counters and mode.
// ----------------------------------------------------------------------------
module byte_run_length_decoder_unit #(
    parameter int LENGTH_BITS = brld_pkg::LENGTH_BITS_DEFAULT
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [brld_pkg::CFG_INDEX_BITS-1:0]  i_cfg_index,
    input  logic [LENGTH_BITS-1:0]               i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [brld_pkg::BYTE_BITS-1:0]       i_in_byte,
    input  logic                                 i_stream_start,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [brld_pkg::BYTE_BITS-1:0]       o_byte_a,
    output logic [brld_pkg::BYTE_BITS-1:0]       o_byte_b,
    output logic [brld_pkg::COUNT_BITS-1:0]      o_byte_count,
    output logic [1:0]                           o_error_code,
    output logic                                 o_run_last,
    output logic                                 o_stream_done
);
    import brld_pkg::*;

    t_cmd    cmd;
    t_status status;

    brld_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_stream_start (i_stream_start),
        .i_status       (status),
        .o_in_stall     (o_in_stall),
        .o_cmd          (cmd)
    );

    brld_dp #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_byte     (i_in_byte),
        .i_out_stall   (i_out_stall),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_out_valid   (o_out_valid),
        .o_byte_a      (o_byte_a),
        .o_byte_b      (o_byte_b),
        .o_byte_count  (o_byte_count),
        .o_error_code  (o_error_code),
        .o_run_last    (o_run_last),
        .o_stream_done (o_stream_done)
    );

endmodule
